// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the ranger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URAV_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ranger assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define URAV_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ranger assertion failed");

`endif

// ----- rtl/core/urav_pkg.sv -----
// Package with the word types, widths and codes of the ultrasonic ranger.
`timescale 1ns / 1ps
`default_nettype none

package urav_pkg;

    localparam int DIST_W    = 22;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = 30;
    localparam int RAW_LSB   = 8;

    localparam logic [PROD_W-1:0] SCALE_NUM     = 30'd11509;
    localparam logic [CFG_W-1:0]  TRIG_LEN_RST  = 16'd1000;
    localparam logic [CFG_W-1:0]  TICK_DIV_RST  = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_CYCLES = 1'b0,
        CFG_TICK_DIVIDER   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_word_t;

    typedef struct packed {
        logic              trig_level;
        logic              done_res;
        logic [DIST_W-1:0] distance_raw;
        logic [DIST_W-1:0] distance_avg;
        logic              busy_res;
    } out_word_t;

    typedef struct packed {
        logic              trig;
        logic              done;
        logic              busy;
        logic [DIST_W-1:0] raw;
    } meas_t;

endpackage

`default_nettype wire

// ----- rtl/core/urav_echo.sv -----
// Measurement sequencer: trigger pulse, echo wait and prescaled tick counting.
`timescale 1ns / 1ps
`default_nettype none

module urav_echo #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        start_req,
    input  logic                        echo_level,
    input  logic [urav_pkg::CFG_W-1:0]  trig_len,
    input  logic [urav_pkg::CFG_W-1:0]  tick_div,
    output urav_pkg::meas_t             meas
);
    import urav_pkg::*;

    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    phase_t              phase_reg, phase_next, phase_eff;
    logic [CFG_W-1:0]    phase_cnt_reg, phase_cnt_next;
    logic [CFG_W-1:0]    pre_cnt_reg, pre_cnt_next;
    logic [TICK_WIDTH-1:0] ticks_reg, ticks_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic [CFG_W-1:0]    trig_len_eff, tick_div_eff;
    logic [CFG_W-1:0]    phase_cnt_inc, pre_base, pre_inc;
    logic [TICK_WIDTH-1:0] ticks_base;
    logic [PROD_W-1:0]   prod_base;
    logic                tick_hit;

    assign trig_len_eff = (trig_len == '0) ? CFG_W'(1) : trig_len;
    assign tick_div_eff = (tick_div == '0) ? CFG_W'(1) : tick_div;

    assign phase_eff = (phase_reg == PH_IDLE && start_req) ? PH_TRIG : phase_reg;

    // Entering the count phase restarts the prescaler and the tick count.
    assign pre_base   = (phase_eff == PH_WAIT) ? '0 : pre_cnt_reg;
    assign ticks_base = (phase_eff == PH_WAIT) ? '0 : ticks_reg;
    assign prod_base  = (phase_eff == PH_WAIT) ? '0 : prod_reg;

    assign phase_cnt_inc = phase_cnt_reg + CFG_W'(1);
    assign pre_inc       = pre_base + CFG_W'(1);
    assign tick_hit      = (pre_inc >= tick_div_eff) || (pre_inc == '0);

    always_comb
    begin
        phase_next     = phase_eff;
        phase_cnt_next = (phase_reg == PH_IDLE && start_req) ? '0 : phase_cnt_reg;
        pre_cnt_next   = pre_cnt_reg;
        ticks_next     = ticks_reg;
        prod_next      = prod_reg;
        case (phase_eff)
            PH_TRIG:
            begin
                if (phase_cnt_inc >= trig_len_eff || phase_cnt_inc == '0)
                begin
                    phase_next     = PH_WAIT;
                    phase_cnt_next = '0;
                end
                else
                begin
                    phase_cnt_next = phase_cnt_inc;
                end
            end
            PH_WAIT, PH_COUNT:
            begin
                if (echo_level)
                begin
                    phase_next   = PH_COUNT;
                    pre_cnt_next = tick_hit ? '0 : pre_inc;
                    ticks_next   = ticks_base;
                    prod_next    = prod_base;
                    if (tick_hit && ticks_base != TICK_MAX)
                    begin
                        ticks_next = ticks_base + TICK_WIDTH'(1);
                        prod_next  = prod_base + SCALE_NUM;
                    end
                end
                else if (phase_eff == PH_COUNT)
                begin
                    phase_next     = PH_IDLE;
                    phase_cnt_next = '0;
                    pre_cnt_next   = '0;
                end
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase
    end

    always_comb
    begin
        meas.trig = (phase_eff == PH_TRIG);
        meas.done = (phase_eff == PH_COUNT) && !echo_level;
        meas.busy = (phase_next != PH_IDLE);
        meas.raw  = meas.done ? prod_reg[PROD_W-1:RAW_LSB] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            phase_cnt_reg <= '0;
            pre_cnt_reg   <= '0;
            ticks_reg     <= '0;
            prod_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            phase_cnt_reg <= phase_cnt_next;
            pre_cnt_reg   <= pre_cnt_next;
            ticks_reg     <= ticks_next;
            prod_reg      <= prod_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/urav_avg.sv -----
// Sample ring with a running sum kept one entry ahead of the next write.
`timescale 1ns / 1ps
`default_nettype none

module urav_avg #(
    parameter int RING_SIZE = 5
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           push,
    input  logic [urav_pkg::DIST_W-1:0]                    raw,
    output logic [urav_pkg::DIST_W+$clog2(RING_SIZE)-1:0]  sum_new,
    output logic                                           full
);
    import urav_pkg::*;

    localparam int SUM_W = DIST_W + $clog2(RING_SIZE);
    localparam int IDX_W = $clog2(RING_SIZE);
    localparam int CNT_W = $clog2(RING_SIZE + 1);

    logic [DIST_W-1:0] ring_reg [RING_SIZE];
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    // Sum of the ring minus the entry that the next push replaces.
    logic [SUM_W-1:0]  part_reg;

    logic [IDX_W-1:0]  next1, next2;

    assign next1 = (idx_reg == IDX_W'(RING_SIZE - 1)) ? '0 : idx_reg + IDX_W'(1);
    assign next2 = (next1 == IDX_W'(RING_SIZE - 1)) ? '0 : next1 + IDX_W'(1);

    assign sum_new    = part_reg + {{(SUM_W-DIST_W){1'b0}}, raw};
    assign count_next = (count_reg == CNT_W'(RING_SIZE)) ? count_reg
                                                          : count_reg + CNT_W'(1);
    assign full       = (count_next == CNT_W'(RING_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_SIZE; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg   <= '0;
            count_reg <= '0;
            part_reg  <= '0;
        end
        else if (push)
        begin
            ring_reg[next1] <= raw;
            idx_reg         <= next1;
            count_reg       <= count_next;
            part_reg        <= sum_new - {{(SUM_W-DIST_W){1'b0}}, ring_reg[next2]};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_ranger_avg.sv -----
// A word accepted at an edge is registered into stage one, then into the output register.
// Throughput: one word per cycle while in_ready is high; the sequencer and ring update in
// the first stage, the divide-by-ring-size multiply in the second.
// Reset: asynchronous and active low; it clears the phase, counters, ring,
// average and the valid flags of both stages, and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_ranger_avg #(
    parameter int RING_SIZE  = 5,
    parameter int TICK_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  urav_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output urav_pkg::out_word_t             out_data,
    input  logic                            cfg_we,
    input  logic [urav_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urav_pkg::CFG_W-1:0]      cfg_data
);
    import urav_pkg::*;

    localparam int SUM_W  = DIST_W + $clog2(RING_SIZE);
    localparam int DIV_SH = SUM_W + $clog2(RING_SIZE);
    localparam int MUL_W  = SUM_W + 1;
    localparam logic [63:0] DIV_M = ((64'd1 << DIV_SH) + RING_SIZE - 1) / RING_SIZE;
    localparam logic [MUL_W-1:0] DIV_M_C = DIV_M[MUL_W-1:0];

    logic [CFG_W-1:0] trig_len_reg, tick_div_reg;

    logic              accept, out_load;
    meas_t             meas;
    logic [SUM_W-1:0]  sum_new;
    logic              full;

    logic              s1_valid_reg;
    meas_t             s1_meas_reg;
    logic [SUM_W-1:0]  s1_sum_reg;
    logic              s1_full_reg;

    logic              out_valid_reg;
    out_word_t         out_data_reg, out_data_next;
    logic [DIST_W-1:0] last_avg_reg, avg_next;

    logic [SUM_W+MUL_W-1:0] div_prod;
    logic [DIST_W-1:0]      quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_len_reg <= TRIG_LEN_RST;
            tick_div_reg <= TICK_DIV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_TRIGGER_CYCLES: trig_len_reg <= cfg_data;
                CFG_TICK_DIVIDER:   tick_div_reg <= cfg_data;
                default:            trig_len_reg <= trig_len_reg;
            endcase
        end
    end

    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    urav_echo #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_echo (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .start_req  (in_data.start_req),
        .echo_level (in_data.echo_level),
        .trig_len   (trig_len_reg),
        .tick_div   (tick_div_reg),
        .meas       (meas)
    );

    urav_avg #(
        .RING_SIZE (RING_SIZE)
    ) u_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept && meas.done),
        .raw     (meas.raw),
        .sum_new (sum_new),
        .full    (full)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meas_reg <= meas;
            s1_sum_reg  <= sum_new;
            s1_full_reg <= full;
        end
    end

    // Division by the ring size as a multiply by its scaled reciprocal.
    assign div_prod = {{MUL_W{1'b0}}, s1_sum_reg} * {{SUM_W{1'b0}}, DIV_M_C};
    assign quot     = div_prod[DIV_SH +: DIST_W];

    always_comb
    begin
        if (s1_meas_reg.done)
        begin
            avg_next = s1_full_reg ? quot : s1_meas_reg.raw;
        end
        else
        begin
            avg_next = last_avg_reg;
        end
        out_data_next.trig_level   = s1_meas_reg.trig;
        out_data_next.done_res     = s1_meas_reg.done;
        out_data_next.distance_raw = s1_meas_reg.raw;
        out_data_next.distance_avg = avg_next;
        out_data_next.busy_res     = s1_meas_reg.busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_avg_reg  <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                last_avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/urav_checker.sv -----
// Port-level checker for the ranger and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module urav_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  urav_pkg::out_word_t  out_data
);
    import urav_pkg::*;

    logic out_stall, out_done, out_plain, out_trig;

    assign out_stall = out_valid && !out_ready;
    assign out_done  = out_valid && out_data.done_res;
    assign out_plain = out_valid && !out_data.done_res;
    assign out_trig  = out_valid && out_data.trig_level;

    // A result word that is not taken stays put.
    `URAV_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))

    // The completing word ends the measurement and carries no trigger drive.
    `URAV_ASSERT_IMP(a_done_idle, clk, rst_n, out_done, !out_data.busy_res && !out_data.trig_level)

    // Without a completion the raw distance is zero.
    `URAV_ASSERT_IMP(a_raw_zero, clk, rst_n, out_plain, out_data.distance_raw == '0)

    // The trigger is only driven inside a measurement.
    `URAV_ASSERT_IMP(a_trig_busy, clk, rst_n, out_trig, out_data.busy_res)

endmodule

bind ultrasonic_ranger_avg urav_checker u_checker (.*);

`default_nettype wire
